FILE: rtl/pse_pkg.sv
// Shared types, constants and the microcode program of the prime sieve engine.
package pse_pkg;

  localparam int MAX_BOUND   = 16384;
  localparam int PRIME_SLOTS = 2048;

  localparam int BOUND_W = 15;
  localparam int RANK_W  = 11;
  localparam int VALUE_W = 14;
  localparam int COUNT_W = 12;

  // map holds odd numbers only: entry k stands for 2k+1
  localparam int MAP_AW  = $clog2(MAX_BOUND) - 1;
  localparam int MAP_DEP = MAX_BOUND / 2;
  localparam int LIST_AW = $clog2(PRIME_SLOTS);
  // i stays below sqrt(MAX_BOUND)+2 in the outer loop
  localparam int SQ_W    = $clog2(MAX_BOUND) / 2 + 1;
  localparam int J_W     = BOUND_W + 1;
  localparam int PC_W    = 5;

  localparam logic [BOUND_W-1:0] BOUND_SAT = BOUND_W'(MAX_BOUND);
  localparam logic [COUNT_W-1:0] SLOTS_FULL = COUNT_W'(PRIME_SLOTS);

  typedef enum logic [1:0] {I_HOLD, I_LOAD3, I_ADD2} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_LOADSQ, J_ADDSTEP} j_op_t;
  typedef enum logic [1:0] {M_NONE, M_SET, M_CLR} map_op_t;
  typedef enum logic [1:0] {L_NONE, L_TWO, L_CAND} list_op_t;
  typedef enum logic [1:0] {F_NONE, F_BUILD, F_QUERY} fin_t;
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_QUERY, C_SMALL, C_I_GE_N,
    C_SQ_GE_N, C_MAP_CLR, C_J_GE_N, C_FULL
  } cond_t;

  typedef struct packed {
    i_op_t            i_op;
    j_op_t            j_op;
    map_op_t          map_op;
    list_op_t         list_op;
    fin_t             fin;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic     accept;
    i_op_t    i_op;
    j_op_t    j_op;
    map_op_t  map_op;
    list_op_t list_op;
    fin_t     fin;
  } ctrl_t;

  // flags from datapath to sequencer
  typedef struct packed {
    logic query;
    logic n_le2;
    logic i_ge_n;
    logic sq_ge_n;
    logic map_clr;
    logic j_ge_n;
    logic full;
  } flags_t;

  localparam logic [PC_W-1:0] A_DISPATCH = 5'd0;
  localparam logic [PC_W-1:0] A_INIT     = 5'd1;
  localparam logic [PC_W-1:0] A_CLR_TEST = 5'd2;
  localparam logic [PC_W-1:0] A_CLR_SET  = 5'd3;
  localparam logic [PC_W-1:0] A_SIEVE    = 5'd4;
  localparam logic [PC_W-1:0] A_OUTER    = 5'd5;
  localparam logic [PC_W-1:0] A_SQ_TEST  = 5'd6;
  localparam logic [PC_W-1:0] A_MARK     = 5'd7;
  localparam logic [PC_W-1:0] A_INNER    = 5'd8;
  localparam logic [PC_W-1:0] A_STRIKE   = 5'd9;
  localparam logic [PC_W-1:0] A_NEXT_I   = 5'd10;
  localparam logic [PC_W-1:0] A_COLLECT  = 5'd11;
  localparam logic [PC_W-1:0] A_C_LOOP   = 5'd12;
  localparam logic [PC_W-1:0] A_C_TEST   = 5'd13;
  localparam logic [PC_W-1:0] A_C_STORE  = 5'd14;
  localparam logic [PC_W-1:0] A_C_NEXT   = 5'd15;
  localparam logic [PC_W-1:0] A_DONE     = 5'd16;
  localparam logic [PC_W-1:0] A_QUERY    = 5'd17;

  function automatic ucode_t uword(i_op_t io, j_op_t jo, map_op_t mo, list_op_t lo,
                                   fin_t f, cond_t c, logic [PC_W-1:0] t);
    ucode_t w;
    w.i_op    = io;
    w.j_op    = jo;
    w.map_op  = mo;
    w.list_op = lo;
    w.fin     = f;
    w.cond    = c;
    w.target  = t;
    return w;
  endfunction

  // jump is taken when cond holds, otherwise fall through to pc+1
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      A_DISPATCH: w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_QUERY,   A_QUERY);
      A_INIT:     w = uword(I_LOAD3, J_HOLD,    M_NONE, L_NONE, F_NONE,  C_SMALL,   A_DONE);
      A_CLR_TEST: w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_I_GE_N,  A_SIEVE);
      A_CLR_SET:  w = uword(I_ADD2,  J_HOLD,    M_SET,  L_NONE, F_NONE,  C_ALWAYS,  A_CLR_TEST);
      A_SIEVE:    w = uword(I_LOAD3, J_HOLD,    M_NONE, L_NONE, F_NONE,  C_NEVER,   A_OUTER);
      A_OUTER:    w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_NEVER,   A_SQ_TEST);
      A_SQ_TEST:  w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_SQ_GE_N, A_COLLECT);
      A_MARK:     w = uword(I_HOLD,  J_LOADSQ,  M_NONE, L_NONE, F_NONE,  C_MAP_CLR, A_NEXT_I);
      A_INNER:    w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_J_GE_N,  A_NEXT_I);
      A_STRIKE:   w = uword(I_HOLD,  J_ADDSTEP, M_CLR,  L_NONE, F_NONE,  C_ALWAYS,  A_INNER);
      A_NEXT_I:   w = uword(I_ADD2,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_ALWAYS,  A_OUTER);
      A_COLLECT:  w = uword(I_LOAD3, J_HOLD,    M_NONE, L_TWO,  F_NONE,  C_NEVER,   A_C_LOOP);
      A_C_LOOP:   w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_FULL,    A_DONE);
      A_C_TEST:   w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_MAP_CLR, A_C_NEXT);
      A_C_STORE:  w = uword(I_HOLD,  J_HOLD,    M_NONE, L_CAND, F_NONE,  C_NEVER,   A_C_NEXT);
      A_C_NEXT:   w = uword(I_ADD2,  J_HOLD,    M_NONE, L_NONE, F_NONE,  C_ALWAYS,  A_C_LOOP);
      A_DONE:     w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_BUILD, C_NEVER,   A_DISPATCH);
      A_QUERY:    w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_QUERY, C_NEVER,   A_DISPATCH);
      default:    w = uword(I_HOLD,  J_HOLD,    M_NONE, L_NONE, F_BUILD, C_NEVER,   A_DISPATCH);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/pse_sequencer.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module pse_sequencer import pse_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  flags_t flags,
  output logic   busy,
  output ctrl_t  ctrl
);

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_RUN = 2'b10} seq_state_t;

  seq_state_t       state_r, state_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  ucode_t           word;
  logic             taken;

  assign word = ucode_rom(pc_r);

  always_comb begin
    case (word.cond)
      C_NEVER:   taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_QUERY:   taken = flags.query;
      C_SMALL:   taken = flags.n_le2;
      C_I_GE_N:  taken = flags.i_ge_n;
      C_SQ_GE_N: taken = flags.sq_ge_n;
      C_MAP_CLR: taken = flags.map_clr;
      C_J_GE_N:  taken = flags.j_ge_n;
      C_FULL:    taken = flags.full;
      default:   taken = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          pc_nxt    = A_DISPATCH;
        end
      end
      S_RUN: begin
        pc_nxt = taken ? word.target : pc_r + PC_W'(1);
        if (word.fin != F_NONE) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= A_DISPATCH;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    ctrl         = '0;
    ctrl.accept  = start && (state_r == S_IDLE);
    if (state_r == S_RUN) begin
      ctrl.i_op    = word.i_op;
      ctrl.j_op    = word.j_op;
      ctrl.map_op  = word.map_op;
      ctrl.list_op = word.list_op;
      ctrl.fin     = word.fin;
    end
  end

endmodule

FILE: rtl/pse_datapath.sv
// Sieve datapath: index registers, candidate map, prime list and result register.
module pse_datapath import pse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  input  logic               in_op,
  input  logic [BOUND_W-1:0] in_bound,
  input  logic [RANK_W-1:0]  in_rank,
  output flags_t             flags,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_prime_value,
  output logic [COUNT_W-1:0] out_prime_count,
  output logic               out_found
);

  logic               op_r;
  logic [BOUND_W-1:0] n_r;
  logic [RANK_W-1:0]  rank_r;
  logic [BOUND_W-1:0] i_r, i_nxt;
  logic [J_W-1:0]     j_r, j_nxt;
  logic [J_W-1:0]     sq_r;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] count_r;

  logic               map_mem [MAP_DEP];
  logic [VALUE_W-1:0] list_mem [PRIME_SLOTS];
  logic               map_rd_r;
  logic [VALUE_W-1:0] list_rd_r;

  logic               valid_r;
  logic [VALUE_W-1:0] value_r;
  logic [COUNT_W-1:0] pcount_r;
  logic               found_r;

  logic [SQ_W-1:0]    i_lo;
  logic [J_W-1:0]     j_step;
  logic               rank_hit;

  assign i_lo     = i_r[SQ_W-1:0];
  assign j_step   = J_W'({i_lo, 1'b0});
  assign rank_hit = {1'b0, rank_r} < count_r;

  always_comb begin
    case (ctrl.i_op)
      I_LOAD3: i_nxt = BOUND_W'(3);
      I_ADD2:  i_nxt = i_r + BOUND_W'(2);
      default: i_nxt = i_r;
    endcase
    case (ctrl.j_op)
      J_LOADSQ:  j_nxt = sq_r;
      J_ADDSTEP: j_nxt = j_r + j_step;
      default:   j_nxt = j_r;
    endcase
    cnt_nxt = cnt_r;
    if (ctrl.accept) begin
      cnt_nxt = '0;
    end else if (ctrl.list_op != L_NONE) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op_r   <= in_op;
      n_r    <= (in_bound > BOUND_SAT) ? BOUND_SAT : in_bound;
      rank_r <= in_rank;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    sq_r  <= J_W'(i_lo) * J_W'(i_lo);
  end

  // candidate map: write at i (set) or j (strike), read at i
  always_ff @(posedge clk) begin
    if (ctrl.map_op == M_SET) begin
      map_mem[i_r[MAP_AW:1]] <= 1'b1;
    end else if (ctrl.map_op == M_CLR) begin
      map_mem[j_r[MAP_AW:1]] <= 1'b0;
    end
    map_rd_r <= map_mem[i_r[MAP_AW:1]];
  end

  always_ff @(posedge clk) begin
    if (ctrl.list_op == L_TWO) begin
      list_mem[cnt_r[LIST_AW-1:0]] <= VALUE_W'(2);
    end else if (ctrl.list_op == L_CAND) begin
      list_mem[cnt_r[LIST_AW-1:0]] <= i_r[VALUE_W-1:0];
    end
    list_rd_r <= list_mem[rank_r];
  end

  always_comb begin
    flags.query   = op_r;
    flags.n_le2   = n_r <= BOUND_W'(2);
    flags.i_ge_n  = i_r >= n_r;
    flags.sq_ge_n = sq_r >= J_W'(n_r);
    flags.map_clr = !map_rd_r;
    flags.j_ge_n  = j_r >= J_W'(n_r);
    flags.full    = (i_r >= n_r) || (cnt_r == SLOTS_FULL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (ctrl.fin != F_NONE);
      if (ctrl.fin == F_BUILD) begin
        count_r <= cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin == F_BUILD) begin
      value_r  <= '0;
      pcount_r <= cnt_r;
      found_r  <= 1'b0;
    end else if (ctrl.fin == F_QUERY) begin
      value_r  <= rank_hit ? list_rd_r : '0;
      pcount_r <= count_r;
      found_r  <= rank_hit;
    end
  end

  assign out_valid       = valid_r;
  assign out_prime_value = value_r;
  assign out_prime_count = pcount_r;
  assign out_found       = found_r;

endmodule

FILE: rtl/prime_sieve_engine.sv
// Top level of the prime sieve engine: sequencer plus datapath.
//
// Command channel: present in_op/in_bound/in_rank with start; the transfer
// happens at a rising edge with start high and busy low. busy drops in the
// cycle that carries the item's result strobe.
// Build (in_op = 0): sieves the odd numbers below in_bound (saturated to
// 16384) and lists 2 plus every surviving odd number. A build walks the map
// about three times under the control program: it sets a candidate per odd
// number, tests each odd i up to the square root and, for a sieving prime,
// strikes its odd multiples from i*i, and then collects the surviving odd
// numbers into the list. Bounds of 2 or less skip straight to the done step.
// Query (in_op = 1): reads the prime list at in_rank.
// Result channel: out_valid is high for one cycle with out_prime_value,
// out_prime_count and out_found; the receiver cannot stall it. A new
// command can transfer at the edge that ends the result strobe cycle.
// Reset clears the prime count to zero; map and list are not cleared, a
// query only reads entries that the last build wrote.
module prime_sieve_engine import pse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [BOUND_W-1:0] in_bound,
  input  logic [RANK_W-1:0]  in_rank,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_prime_value,
  output logic [COUNT_W-1:0] out_prime_count,
  output logic               out_found
);

  ctrl_t  ctrl;
  flags_t flags;

  pse_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  pse_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_op           (in_op),
    .in_bound        (in_bound),
    .in_rank         (in_rank),
    .flags           (flags),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_prime_count (out_prime_count),
    .out_found       (out_found)
  );

endmodule

FILE: verif/prime_sieve_engine_tb.sv
// Testbench for prime_sieve_engine: directed and random builds and queries.
`timescale 1ns / 1ps

module prime_sieve_engine_tb;
  import pse_pkg::*;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int   CYCLE_LIMIT = 4000000;
  localparam int   DRAIN_CYCLES = 20;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               found;
  } sieve_result_t;

  class sieve_scoreboard;
    logic [VALUE_W-1:0] prime_tab [PRIME_SLOTS];
    int                 prime_total;
    sieve_result_t      expected_q [$];
    int                 errors;

    function new();
      prime_total = 0;
      errors = 0;
    endfunction

    // sieve over odd numbers below n, refill the prime table
    function void rebuild(int n);
      bit composite [MAX_BOUND];
      int cnt;
      foreach (composite[k]) composite[k] = 1'b0;
      if (n > MAX_BOUND) n = MAX_BOUND;
      prime_total = 0;
      if (n <= 2) return;
      for (int i = 3; i * i < n; i += 2)
        if (!composite[i])
          for (int j = i * i; j < n; j += i) composite[j] = 1'b1;
      cnt = 0;
      prime_tab[cnt++] = VALUE_W'(2);
      for (int i = 3; i < n && cnt < PRIME_SLOTS; i += 2)
        if (!composite[i]) prime_tab[cnt++] = VALUE_W'(i);
      prime_total = cnt;
    endfunction

    function void note_item(logic op, logic [BOUND_W-1:0] bound, logic [RANK_W-1:0] rank);
      sieve_result_t r;
      r.value = '0;
      r.found = 1'b0;
      if (op == OP_BUILD) begin
        rebuild(int'(bound));
      end else if (int'(rank) < prime_total) begin
        r.value = prime_tab[rank];
        r.found = 1'b1;
      end
      r.count = COUNT_W'(prime_total);
      expected_q = {expected_q, r};
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count,
                               logic found);
      sieve_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d count=%0d found=%0d",
                 $time, value, count, found);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (value !== r.value) begin
        $display("%0t: prime_value expected %0d actual %0d", $time, r.value, value);
        errors++;
      end
      if (count !== r.count) begin
        $display("%0t: prime_count expected %0d actual %0d", $time, r.count, count);
        errors++;
      end
      if (found !== r.found) begin
        $display("%0t: found expected %0d actual %0d", $time, r.found, found);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = OP_BUILD;
  logic [BOUND_W-1:0] in_bound = '0;
  logic [RANK_W-1:0]  in_rank = '0;
  logic               out_valid;
  logic [VALUE_W-1:0] out_prime_value;
  logic [COUNT_W-1:0] out_prime_count;
  logic               out_found;

  sieve_scoreboard sb;
  int              idle_pct = 0;
  int              big_builds_left = 2;
  int              cycles = 0;

  prime_sieve_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_bound        (in_bound),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_prime_count (out_prime_count),
    .out_found       (out_found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("prime_sieve_engine_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_prime_value, out_prime_count, out_found);
  end

  // start stays high across back-to-back transfers; dropped only for a gap
  task automatic issue(input logic op, input logic [BOUND_W-1:0] bound,
                       input logic [RANK_W-1:0] rank);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_bound <= bound;
    in_rank  <= rank;
    do @(posedge clk); while (busy);
    sb.note_item(op, bound, rank);
  endtask

  task automatic issue_random();
    int sel;
    int hi;
    logic [BOUND_W-1:0] bound;
    logic [RANK_W-1:0]  rank;
    bound = BOUND_W'($urandom);
    rank  = RANK_W'($urandom);
    if ($urandom_range(99) < 35) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        bound = BOUND_W'($urandom_range(0, 700));
      end else if (sel < 96 || big_builds_left == 0) begin
        bound = BOUND_W'($urandom_range(700, 4000));
      end else begin
        bound = BOUND_W'($urandom_range(4000, 32767));
        big_builds_left--;
      end
      issue(OP_BUILD, bound, rank);
    end else begin
      // mostly ranks around the live list, including the first miss
      if ($urandom_range(99) < 75) begin
        hi = sb.prime_total + 2;
        if (hi > 2047) hi = 2047;
        rank = RANK_W'($urandom_range(0, hi));
      end
      issue(OP_QUERY, bound, rank);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 22;
    issue(OP_QUERY, '0, '0);            // query before any build
    issue(OP_BUILD, '0, '1);
    issue(OP_QUERY, '1, 0);
    issue(OP_BUILD, 1, 0);
    issue(OP_BUILD, 2, 0);
    issue(OP_QUERY, 0, 0);
    issue(OP_BUILD, 3, 0);              // only prime 2
    issue(OP_QUERY, 0, 0);
    issue(OP_QUERY, 0, 1);
    issue(OP_BUILD, 10, 0);
    issue(OP_QUERY, 0, 3);
    issue(OP_QUERY, 0, 4);
    issue(OP_BUILD, BOUND_W'(MAX_BOUND), 0);
    issue(OP_QUERY, 0, 1899);
    issue(OP_QUERY, 0, 1900);
    issue(OP_QUERY, 0, '1);
    issue(OP_BUILD, '1, 0);             // saturates to the maximum bound
    issue(OP_QUERY, 0, 0);
    issue(OP_QUERY, 0, 1899);
    issue(OP_BUILD, 100, 0);
    issue(OP_QUERY, 0, 24);
    issue(OP_QUERY, 0, 25);

    for (int n = 0; n < 26; n++) issue_random();
    idle_pct = 81;
    for (int n = 0; n < 26; n++) issue_random();
    idle_pct = 0;
    for (int n = 0; n < 26; n++) issue_random();
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("prime_sieve_engine_tb OK");
    end else begin
      $display("prime_sieve_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
